FILE: hw/rtl/ntte_pkg.sv
// Package for the transmit tag and event engine: sizes, codes and state type.
// No dependencies; imported by ntte_ram users and the top level.
`timescale 1ns / 1ps

package ntte_pkg;

    localparam int NUM_TAGS       = 64;
    localparam int NUM_RX_BUFFERS = 64;
    localparam int MTU_BYTES      = 8192;

    localparam int TAG_AW = $clog2(NUM_TAGS);   // tag index bits
    localparam int TAG_W  = TAG_AW + 1;         // head/link bits, NUM_TAGS means end

    localparam int PAY_W   = 14;
    localparam int ADDR_W  = 16;
    localparam int EVENT_W = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int HALF_W  = 16;
    localparam int QLEN_W  = 12;

    localparam logic [HALF_W-1:0] EV_TX_DONE  = 16'd125;
    localparam logic [HALF_W-1:0] EV_RX       = 16'd126;
    localparam logic [HALF_W-1:0] EV_CRC_ERR  = 16'd135;
    localparam logic [HALF_W-1:0] NODE_STRIDE = 16'd254;

    localparam logic [KIND_W-1:0] KIND_TX_CMD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RX        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TX_DONE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CRC_ERR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNHANDLED = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_TAG   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_IDX  = 2'd2;

    localparam logic MODE_TX    = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: hw/rtl/ntte_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ntte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/nic_tx_tag_and_event_engine.sv
// Transmit tag allocator (LIFO free list in RAM) and completion event decoder.
// Depends on ntte_pkg and ntte_ram.
//
//  channel | ports             | tuser       | tdata
//  --------+-------------------+-------------+-------------------------------------
//  input   | s_tvalid/s_tready | mode        | payload_bytes, dest_addr_low, event_word
//  result  | m_tvalid/m_tready | kind        | status, tag_or_index, node_id, quad_length,
//          |                   |             | event_type
//
// For each item, the accept cycle reads the link entry at the list head from the
// RAM, the next cycle uses the read data, updates the head and the link RAM, and
// loads the output register. One item is in work at a time.
// Reset empties the output register and rebuilds the free list at once through
// per-entry valid bits; no clearing pass. A stalled output holds the result in the
// output register; the next item is still accepted and then waits in the work
// cycle until that register can be refilled. No item is accepted during reset.
`timescale 1ns / 1ps

module nic_tx_tag_and_event_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // mode
    input  logic [63:0] s_tdata,   // payload_bytes[13:0], dest_addr_low[29:14],
                                   // event_word[61:30], zero[63:62]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ntte_pkg::KIND_W-1:0] m_tuser,  // kind
    output logic [63:0] m_tdata    // status[1:0], tag_or_index[17:2], node_id[33:18],
                                   // quad_length[45:34], event_type[61:46], zero[63:62]
);

    import ntte_pkg::*;

    state_t state_reg, state_next;

    logic                mode_reg;
    logic [PAY_W-1:0]    pay_reg;
    logic [ADDR_W-1:0]   dest_reg;
    logic [EVENT_W-1:0]  ev_reg;

    logic [TAG_W-1:0]    free_head_reg, free_head_next;
    logic [NUM_TAGS-1:0] valid_reg, valid_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [HALF_W-1:0]   tag_reg, tag_next;
    logic [HALF_W-1:0]   node_reg, node_next;
    logic [QLEN_W-1:0]   qlen_reg, qlen_next;
    logic [HALF_W-1:0]   etype_reg, etype_next;

    logic                in_take;
    logic                exec_done;
    logic                out_free;

    logic                ram_we;
    logic [TAG_AW-1:0]   ram_waddr;
    logic [TAG_W-1:0]    ram_wdata;
    logic [TAG_W-1:0]    ram_rdata;

    logic [TAG_AW-1:0]   head_idx;
    logic [TAG_W-1:0]    link_val;
    logic [HALF_W-1:0]   ev_type;
    logic [HALF_W-1:0]   ev_idx;
    logic [HALF_W-1:0]   x_prod;
    logic [PAY_W-1:0]    pay_clamped;
    logic [PAY_W:0]      pay_sum;
    logic [PAY_W-2:0]    quads;

    ntte_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_TAGS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_idx),
        .rdata (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign head_idx = free_head_reg[TAG_AW-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_done = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = aresetn;
            ST_EXEC: exec_done = out_free;
            default: ;
        endcase
    end

    assign in_take = s_tvalid && s_tready;

    // datapath for the item in work
    always_comb begin
        ev_type = ev_reg[31:16];
        ev_idx  = ev_reg[15:0];

        // entries never written since reset hold their initial link
        if (valid_reg[head_idx]) begin
            link_val = ram_rdata;
        end else if (head_idx == '0) begin
            link_val = TAG_W'(NUM_TAGS);
        end else begin
            link_val = TAG_W'(head_idx) - TAG_W'(1);
        end

        x_prod      = {8'd0, dest_reg[15:8]} * NODE_STRIDE;
        pay_clamped = (pay_reg > PAY_W'(MTU_BYTES)) ? PAY_W'(MTU_BYTES) : pay_reg;
        pay_sum     = {1'b0, pay_clamped} + (PAY_W+1)'(4);
        quads       = pay_sum[PAY_W:2] - (PAY_W-1)'(1);

        free_head_next = free_head_reg;
        valid_next     = valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = ev_idx[TAG_AW-1:0];
        ram_wdata      = free_head_reg;

        kind_next   = KIND_UNHANDLED;
        status_next = STAT_OK;
        tag_next    = ev_idx;
        node_next   = '0;
        qlen_next   = '0;
        etype_next  = ev_type;

        if (mode_reg == MODE_TX) begin
            kind_next  = KIND_TX_CMD;
            node_next  = x_prod + {8'd0, dest_reg[7:0]} - HALF_W'(1);
            qlen_next  = quads[QLEN_W-1:0];
            etype_next = '0;
            if (free_head_reg < TAG_W'(NUM_TAGS)) begin
                tag_next = HALF_W'(head_idx);
                if (exec_done) begin
                    free_head_next = (link_val > TAG_W'(NUM_TAGS)) ?
                                     TAG_W'(NUM_TAGS) : link_val;
                end
            end else begin
                status_next = STAT_NO_TAG;
                tag_next    = '0;
            end
        end else if (ev_type == EV_RX) begin
            kind_next = KIND_RX;
            if (ev_idx >= HALF_W'(NUM_RX_BUFFERS)) status_next = STAT_BAD_IDX;
        end else if (ev_type == EV_TX_DONE) begin
            kind_next = KIND_TX_DONE;
            if (ev_idx < HALF_W'(NUM_TAGS)) begin
                if (exec_done) begin
                    ram_we                  = 1'b1;
                    valid_next[ram_waddr]   = 1'b1;
                    free_head_next          = TAG_W'(ev_idx[TAG_AW-1:0]);
                end
            end else begin
                status_next = STAT_BAD_IDX;
            end
        end else if (ev_type == EV_CRC_ERR) begin
            kind_next = KIND_CRC_ERR;
        end

        if (exec_done) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= TAG_W'(NUM_TAGS - 1);
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            valid_reg     <= valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            mode_reg <= s_tuser;
            pay_reg  <= s_tdata[13:0];
            dest_reg <= s_tdata[29:14];
            ev_reg   <= s_tdata[61:30];
        end
        if (exec_done) begin
            kind_reg   <= kind_next;
            status_reg <= status_next;
            tag_reg    <= tag_next;
            node_reg   <= node_next;
            qlen_reg   <= qlen_next;
            etype_reg  <= etype_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {2'b00, etype_reg, qlen_reg, node_reg, tag_reg, status_reg};

endmodule
